>>> rtl/core/gppr_pkg.sv
// gppr_pkg: shared types, constants and widths of the ground-plane perspective remap
// no dependencies; imported by gppr_front, gppr_div_cell and ground_plane_perspective_remap
package gppr_pkg;

  // frame sizes
  localparam int IN_WIDTH   = 640;
  localparam int IN_HEIGHT  = 480;
  localparam int OUT_WIDTH  = 512;
  localparam int OUT_HEIGHT = 512;

  // field widths
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int SRC_COL_W  = 10;
  localparam int SRC_ROW_W  = 9;
  localparam int STEP_W     = 24;
  localparam int SCALE_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // datapath widths
  localparam int GY_W   = COL_W + STEP_W;        // unsigned col/row times step
  localparam int GX_W   = GY_W + 2;              // signed, centered x
  localparam int HT_W   = STEP_W + 1 + TRIG_W;   // height times sin or cos
  localparam int PROD_W = 50;                    // rotated Q.30 values
  localparam int ZC_W   = PROD_W - 14;           // rotated Q.16 values
  localparam int MX_W   = SCALE_W + 1 + GX_W;
  localparam int MY_W   = SCALE_W + 1 + ZC_W;
  localparam int HC_W   = 13;                    // signed half-size constant
  localparam int ZH_W   = ZC_W + HC_W;
  localparam int NUM_W  = 56;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = ZC_W + 4;

  localparam int HALF_W = IN_WIDTH / 2;
  localparam int HALF_H = IN_HEIGHT / 2;
  localparam int MAX_IN = (IN_WIDTH > IN_HEIGHT) ? IN_WIDTH : IN_HEIGHT;
  localparam int QB     = $clog2(MAX_IN);        // quotient bits, one per cell

  localparam int FRONT_STAGES = 7;
  localparam int NUM_STAGES   = FRONT_STAGES + QB + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_STEP,
    REG_Y_STEP,
    REG_X_HALF,
    REG_HEIGHT,
    REG_SCALE,
    REG_COS,
    REG_SIN,
    REG_MIRROR
  } cfg_reg_t;

  typedef struct packed {
    logic [STEP_W-1:0]         x_step;
    logic [STEP_W-1:0]         y_step;
    logic [STEP_W-1:0]         x_half;
    logic [STEP_W-1:0]         height;
    logic [SCALE_W-1:0]        scale;
    logic signed [TRIG_W-1:0]  cos_p;
    logic signed [TRIG_W-1:0]  sin_p;
    logic                      mirror;
  } cfg_t;

  // one axis of the divider: remainder, shifted divisor, quotient so far
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] dsh;
    logic [QB-1:0]    q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t            x;
    lane_t            y;
    logic             zpos;
    logic [ROW_W-1:0] dst_row;
    logic [COL_W-1:0] dst_col;
  } cell_t;

endpackage

>>> rtl/core/gppr_front.sv
// gppr_front: ground mapping, pitch rotation and projection numerators, seven stages
// depends on gppr_pkg; feeds the first divider cell
module gppr_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [gppr_pkg::FRONT_STAGES-1:0]       en_i,
  input  logic                                    in_valid_i,
  input  logic [gppr_pkg::COL_W-1:0]              col_i,
  input  logic [gppr_pkg::ROW_W-1:0]              row_i,
  input  gppr_pkg::cfg_t                          cfg_i,
  output logic [gppr_pkg::FRONT_STAGES-1:0]       vld_o,
  output gppr_pkg::cell_t                         cell_o
);
  import gppr_pkg::*;

  // truncate toward zero on the divide by 2^14
  function automatic logic signed [ZC_W-1:0] tdiv14(input logic signed [PROD_W-1:0] s);
    logic signed [PROD_W-1:0] a;
    a = s[PROD_W-1] ? (s + PROD_W'(16383)) : s;
    return ZC_W'(a >>> 14);
  endfunction

  logic [FRONT_STAGES-1:0] vld_r;
  logic [ROW_W-1:0]        drow_r [FRONT_STAGES];
  logic [COL_W-1:0]        dcol_r [FRONT_STAGES];
  logic [ROW_W-1:0]        drow_nxt;
  logic [COL_W-1:0]        dcol_nxt;

  // stage 0
  logic [GY_W-1:0]        xprod;
  logic signed [GX_W-1:0] gx0_r;
  logic [GY_W-1:0]        gy0_r;
  logic signed [HT_W-1:0] hsin0_r, hcos0_r;
  // stage 1
  logic signed [GX_W-1:0]   gx1_r;
  logic signed [PROD_W-1:0] py1_r, pz1_r;
  logic signed [HT_W-1:0]   hsin1_r, hcos1_r;
  // stage 2
  logic signed [GX_W-1:0] gx2_r;
  logic signed [ZC_W-1:0] yc2_r, zc2_r;
  // stage 3
  logic signed [MX_W-1:0] mx3_r;
  logic signed [MY_W-1:0] my3_r;
  logic signed [ZH_W-1:0] zhx3_r, zhy3_r;
  logic signed [ZC_W-1:0] zc3_r;
  // stage 4
  logic signed [NUM_W-1:0] numx4_r, numy4_r;
  logic [DEN_W-1:0]        den4_r;
  logic                    zpos4_r;
  // stage 5
  logic [MAG_W-1:0] magx5_r, magy5_r;
  logic             negx5_r, negy5_r;
  logic [DEN_W-1:0] den5_r;
  logic             zpos5_r;
  // stage 6
  lane_t laneX6_r, laneY6_r;
  logic  zpos6_r;
  logic [MAG_W-1:0] den_ext;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en_i[0]) vld_r[0] <= in_valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en_i[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // destination address, carried alongside
  assign drow_nxt = ROW_W'(OUT_HEIGHT - 1) - row_i;
  assign dcol_nxt = cfg_i.mirror ? (COL_W'(OUT_WIDTH - 1) - col_i) : col_i;

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      drow_r[0] <= drow_nxt;
      dcol_r[0] <= dcol_nxt;
    end
    for (int k = 1; k < FRONT_STAGES; k++) begin
      if (en_i[k]) begin
        drow_r[k] <= drow_r[k-1];
        dcol_r[k] <= dcol_r[k-1];
      end
    end
  end

  // stage 0: ground coordinates
  assign xprod = GY_W'(col_i) * GY_W'(cfg_i.x_step);

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      gx0_r   <= $signed({2'b00, xprod}) - $signed(GX_W'(cfg_i.x_half));
      gy0_r   <= GY_W'(row_i) * GY_W'(cfg_i.y_step);
      hsin0_r <= $signed({1'b0, cfg_i.height}) * cfg_i.sin_p;
      hcos0_r <= $signed({1'b0, cfg_i.height}) * cfg_i.cos_p;
    end
  end

  // stage 1: rotate depth row by pitch
  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      gx1_r   <= gx0_r;
      py1_r   <= $signed({1'b0, gy0_r}) * cfg_i.cos_p;
      pz1_r   <= $signed({1'b0, gy0_r}) * cfg_i.sin_p;
      hsin1_r <= hsin0_r;
      hcos1_r <= hcos0_r;
    end
  end

  // stage 2: add height terms, back to Q.16
  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      gx2_r <= gx1_r;
      yc2_r <= tdiv14(py1_r + PROD_W'(hsin1_r));
      zc2_r <= tdiv14(pz1_r - PROD_W'(hcos1_r));
    end
  end

  // stage 3: scale products and center offsets
  always_ff @(posedge clk) begin
    if (en_i[3]) begin
      mx3_r  <= $signed({1'b0, cfg_i.scale}) * gx2_r;
      my3_r  <= $signed({1'b0, cfg_i.scale}) * yc2_r;
      zhx3_r <= zc2_r * $signed(HC_W'(HALF_W));
      zhy3_r <= zc2_r * $signed(HC_W'(HALF_H));
      zc3_r  <= zc2_r;
    end
  end

  // stage 4: numerators and divisor (full depth times 16)
  always_ff @(posedge clk) begin
    if (en_i[4]) begin
      numx4_r <= NUM_W'(mx3_r) + (NUM_W'(zhx3_r) <<< 4);
      numy4_r <= NUM_W'(my3_r) + (NUM_W'(zhy3_r) <<< 4);
      den4_r  <= {zc3_r, 4'b0000};
      zpos4_r <= !zc3_r[ZC_W-1] && (zc3_r != '0);
    end
  end

  // stage 5: magnitudes
  always_ff @(posedge clk) begin
    if (en_i[5]) begin
      negx5_r <= numx4_r[NUM_W-1];
      negy5_r <= numy4_r[NUM_W-1];
      magx5_r <= MAG_W'(numx4_r[NUM_W-1] ? -numx4_r : numx4_r);
      magy5_r <= MAG_W'(numy4_r[NUM_W-1] ? -numy4_r : numy4_r);
      den5_r  <= den4_r;
      zpos5_r <= zpos4_r;
    end
  end

  // stage 6: quotient range check and divider seed
  assign den_ext = MAG_W'(den5_r);

  always_ff @(posedge clk) begin
    if (en_i[6]) begin
      laneX6_r.rem <= magx5_r;
      laneX6_r.dsh <= den_ext << (QB - 1);
      laneX6_r.q   <= '0;
      laneX6_r.neg <= negx5_r;
      laneX6_r.ovf <= (magx5_r >> QB) >= den_ext;
      laneY6_r.rem <= magy5_r;
      laneY6_r.dsh <= den_ext << (QB - 1);
      laneY6_r.q   <= '0;
      laneY6_r.neg <= negy5_r;
      laneY6_r.ovf <= (magy5_r >> QB) >= den_ext;
      zpos6_r      <= zpos5_r;
    end
  end

  assign vld_o          = vld_r;
  assign cell_o.x       = laneX6_r;
  assign cell_o.y       = laneY6_r;
  assign cell_o.zpos    = zpos6_r;
  assign cell_o.dst_row = drow_r[FRONT_STAGES-1];
  assign cell_o.dst_col = dcol_r[FRONT_STAGES-1];

endmodule

>>> rtl/core/gppr_div_cell.sv
// gppr_div_cell: one restoring-division step on both axes, one quotient bit per cell
// depends on gppr_pkg; chained QB deep in the top level
module gppr_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en_i,
  input  logic            valid_i,
  input  gppr_pkg::cell_t cell_i,
  output logic            valid_o,
  output gppr_pkg::cell_t cell_o
);
  import gppr_pkg::*;

  // compare, subtract, shift divisor down
  function automatic lane_t lane_step(input lane_t l);
    logic  ge;
    lane_t r;
    ge = l.rem >= l.dsh;
    r = l;
    if (ge) r.rem = l.rem - l.dsh;
    r.q   = (l.q << 1) | QB'(ge);
    r.dsh = l.dsh >> 1;
    return r;
  endfunction

  logic  valid_r;
  cell_t cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en_i) begin
      cell_r.x       <= lane_step(cell_i.x);
      cell_r.y       <= lane_step(cell_i.y);
      cell_r.zpos    <= cell_i.zpos;
      cell_r.dst_row <= cell_i.dst_row;
      cell_r.dst_col <= cell_i.dst_col;
    end
  end

  assign valid_o = valid_r;
  assign cell_o  = cell_r;

endmodule

>>> rtl/core/ground_plane_perspective_remap.sv
// ground_plane_perspective_remap: top level, config registers, stage flow control, output
// depends on gppr_pkg, gppr_front, gppr_div_cell
//
// Usage: one output pixel (out_col, out_row) enters on the in_ channel per transfer and
// exactly one result leaves on the out_ channel, in order: the hit flag, the source
// camera column and row (zero on a miss) and the destination row and column.
// Registers are written through cfg_we/cfg_addr/cfg_wdata, by the user only while the
// block is idle (the block does not enforce this); an index beyond the list is ignored.
// A pixel passes through 18 register stages (the first loads at the transfer edge):
// seven arithmetic stages (ground map, rotation, scaling, numerators, magnitudes,
// range check), then one divider cell per quotient bit (10 cells), then the output
// register.
// Throughput is one item per clock while the receiver takes results; the row of divider
// cells sets the latency and every stage takes a new item each cycle unless stalled.
// When the receiver stalls, results stay in the output register and items keep
// moving into empty stages behind it; in_tready falls only once every stage is full.
// Reset (synchronous, rst_n low) empties all stages and loads the register defaults
// (cos_pitch = 1.0, all others zero).
module ground_plane_perspective_remap (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: out_col[8:0], out_row[17:9], zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gppr_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: hit[0], src_col[10:1], src_row[19:11], dst_row[28:20], dst_col[37:29]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gppr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [gppr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [gppr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gppr_pkg::*;

  cfg_t cfg_r;

  logic [NUM_STAGES-1:0]   en;
  logic [NUM_STAGES-1:0]   vld;
  logic [FRONT_STAGES-1:0] front_vld;
  cell_t                   cell_q [QB+1];
  logic [QB:0]             cell_v;

  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 hit;
  logic                 bad_x, bad_y;
  logic [SRC_COL_W-1:0] src_col;
  logic [SRC_ROW_W-1:0] src_row;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_step <= '0;
      cfg_r.y_step <= '0;
      cfg_r.x_half <= '0;
      cfg_r.height <= '0;
      cfg_r.scale  <= '0;
      cfg_r.cos_p  <= TRIG_W'(16384);
      cfg_r.sin_p  <= '0;
      cfg_r.mirror <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_X_STEP: cfg_r.x_step <= cfg_wdata;
        REG_Y_STEP: cfg_r.y_step <= cfg_wdata;
        REG_X_HALF: cfg_r.x_half <= cfg_wdata;
        REG_HEIGHT: cfg_r.height <= cfg_wdata;
        REG_SCALE:  cfg_r.scale  <= cfg_wdata[SCALE_W-1:0];
        REG_COS:    cfg_r.cos_p  <= $signed(cfg_wdata[TRIG_W-1:0]);
        REG_SIN:    cfg_r.sin_p  <= $signed(cfg_wdata[TRIG_W-1:0]);
        REG_MIRROR: cfg_r.mirror <= cfg_wdata[0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign vld = {out_valid_r, cell_v[QB:1], front_vld};

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  gppr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en_i       (en[FRONT_STAGES-1:0]),
    .in_valid_i (in_tvalid),
    .col_i      (in_tdata[COL_W-1:0]),
    .row_i      (in_tdata[COL_W+ROW_W-1:COL_W]),
    .cfg_i      (cfg_r),
    .vld_o      (front_vld),
    .cell_o     (cell_q[0])
  );

  assign cell_v[0] = front_vld[FRONT_STAGES-1];

  // row of divider cells
  for (genvar i = 0; i < QB; i++) begin : g_cell
    gppr_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en_i    (en[FRONT_STAGES+i]),
      .valid_i (cell_v[i]),
      .cell_i  (cell_q[i]),
      .valid_o (cell_v[i+1]),
      .cell_o  (cell_q[i+1])
    );
  end

  // final range checks; a negative numerator only survives with a zero quotient
  assign bad_x = cell_q[QB].x.ovf || (cell_q[QB].x.neg && (cell_q[QB].x.q != '0));
  assign bad_y = cell_q[QB].y.ovf || (cell_q[QB].y.neg && (cell_q[QB].y.q != '0));
  assign hit   = cell_q[QB].zpos && !bad_x && !bad_y
              && ({1'b0, cell_q[QB].x.q} < (QB+1)'(IN_WIDTH))
              && ({1'b0, cell_q[QB].y.q} < (QB+1)'(IN_HEIGHT));
  assign src_col = hit ? SRC_COL_W'(cell_q[QB].x.q) : '0;
  assign src_row = hit ? SRC_ROW_W'(cell_q[QB].y.q) : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NUM_STAGES-1]) begin
      out_valid_r <= cell_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_data_r <= OUT_DATA_W'({cell_q[QB].dst_col, cell_q[QB].dst_row,
                                 src_row, src_col, hit});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a miss never carries a source address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[19:1] == '0))
    else $error("miss with nonzero source address");

  // a hit lies inside the input frame
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |->
      ((out_tdata[10:1] < SRC_COL_W'(IN_WIDTH)) && (out_tdata[19:11] < SRC_ROW_W'(IN_HEIGHT))))
    else $error("hit outside input frame");

  // input back-pressure only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld))
    else $error("input stalled with an empty stage");

  // an accepted transfer always lands in the first stage
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld[0])
    else $error("accepted transfer lost at first stage");

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for the ground-plane perspective remap
// depends on gppr_pkg and ground_plane_perspective_remap; predicts each pixel remap in a class
module tb_top;
  import gppr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // lowest bit first: hit, src_col, src_row, dst_row, dst_col
  typedef struct packed {
    logic [8:0]       dst_col;
    logic [8:0]       dst_row;
    logic [8:0]       src_row;
    logic [9:0]       src_col;
    logic             hit;
  } remap_t;

  // predicts remap results and holds those not yet seen
  class remap_board;
    longint x_step, y_step, x_half, height, scale, cos_p, sin_p;
    bit mirror;
    remap_t pending[$];
    int errors;

    function void reset_regs();
      x_step = 0; y_step = 0; x_half = 0; height = 0; scale = 0;
      cos_p = 16384; sin_p = 0; mirror = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [23:0] v);
      case (idx)
        REG_X_STEP: x_step = v;
        REG_Y_STEP: y_step = v;
        REG_X_HALF: x_half = v;
        REG_HEIGHT: height = v;
        REG_SCALE:  scale = v[15:0];
        REG_COS:    cos_p = longint'($signed(v[15:0]));
        REG_SIN:    sin_p = longint'($signed(v[15:0]));
        REG_MIRROR: mirror = v[0];
        default: ;
      endcase
    endfunction

    // note an accepted pixel and compute where it maps
    function void note_pixel(logic [8:0] col, logic [8:0] row);
      longint gx, gy, yc, zc, den, sx, sy;
      remap_t r;
      gx = longint'(col) * x_step - x_half;
      gy = longint'(row) * y_step;
      yc = (gy * cos_p + height * sin_p) / 16384;
      zc = (gy * sin_p - height * cos_p) / 16384;
      r = '0;
      if (zc > 0) begin
        den = 16 * zc;
        sx = (scale * gx + den * (IN_WIDTH / 2)) / den;
        sy = (scale * yc + den * (IN_HEIGHT / 2)) / den;
        if (sx >= 0 && sx < IN_WIDTH && sy >= 0 && sy < IN_HEIGHT) begin
          r.hit = 1;
          r.src_col = sx[9:0];
          r.src_row = sy[8:0];
        end
      end
      r.dst_row = 9'(OUT_HEIGHT - 1 - int'(row));
      r.dst_col = mirror ? 9'(OUT_WIDTH - 1 - int'(col)) : col;
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] data);
      remap_t got, exp_r;
      got = data[37:0];
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++;
      end
      if (got.src_col !== exp_r.src_col) begin
        $error("src_col exp %0d got %0d", exp_r.src_col, got.src_col); errors++;
      end
      if (got.src_row !== exp_r.src_row) begin
        $error("src_row exp %0d got %0d", exp_r.src_row, got.src_row); errors++;
      end
      if (got.dst_row !== exp_r.dst_row) begin
        $error("dst_row exp %0d got %0d", exp_r.dst_row, got.dst_row); errors++;
      end
      if (got.dst_col !== exp_r.dst_col) begin
        $error("dst_col exp %0d got %0d", exp_r.dst_col, got.dst_col); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  remap_board board;
  bit calm;        // no idling in the last part
  int hold_off;    // long receiver stall, in cycles
  int cycles;

  always #5 clk = ~clk;

  ground_plane_perspective_remap dut (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sample transfers at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_pixel(in_tdata[8:0], in_tdata[17:9]);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready <= 0;
        hold_off--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_tready <= 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, v);
  endtask

  // offer one pixel and wait for its transfer; tvalid stays up for the next one
  task automatic send_pixel(logic [8:0] col, logic [8:0] row);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      in_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // typical camera setup with random content
  task automatic camera_setup(int pitch_sel);
    write_reg(REG_X_STEP, 24'($urandom_range(200, 3000)));
    write_reg(REG_Y_STEP, 24'($urandom_range(200, 3000)));
    write_reg(REG_X_HALF, 24'($urandom_range(0, 800000)));
    write_reg(REG_HEIGHT, 24'($urandom_range(30000, 200000)));
    write_reg(REG_SCALE, 24'($urandom_range(2000, 12000)));
    case (pitch_sel)
      // cos -1.0, sin 0
      0: begin write_reg(REG_COS, 24'h00c000); write_reg(REG_SIN, 24'd0); end
      1: begin write_reg(REG_COS, 24'd0); write_reg(REG_SIN, 24'h004000); end
      default: begin
        write_reg(REG_COS, 24'(16'(-$urandom_range(5000, 16000))));
        write_reg(REG_SIN, 24'($urandom_range(0, 12000)));
      end
    endcase
    write_reg(REG_MIRROR, 24'($urandom_range(0, 1)));
  endtask

  initial begin
    board = new();
    board.reset_regs();
    repeat (8) @(negedge clk);
    rst_n <= 1;

    // directed: reset defaults give zero depth, then field extremes
    send_pixel(9'd0, 9'd0);
    send_pixel(9'h1ff, 9'h1ff);
    drain();
    write_reg(REG_X_STEP, 24'hffffff);
    write_reg(REG_Y_STEP, 24'hffffff);
    write_reg(REG_X_HALF, 24'hffffff);
    write_reg(REG_HEIGHT, 24'hffffff);
    write_reg(REG_SCALE, 24'h00ffff);
    write_reg(REG_COS, 24'h008000);
    write_reg(REG_SIN, 24'h004000);
    write_reg(REG_MIRROR, 24'd1);
    send_pixel(9'd0, 9'd0); send_pixel(9'h1ff, 9'd0); send_pixel(9'd0, 9'h1ff);
    send_pixel(9'h1ff, 9'h1ff); send_pixel(9'h155, 9'h0aa);
    drain();
    camera_setup(0);
    send_pixel(9'd0, 9'd0); send_pixel(9'd256, 9'd0); send_pixel(9'd511, 9'd511);
    send_pixel(9'd256, 9'd300); send_pixel(9'd10, 9'd100);
    drain();
    camera_setup(1);
    send_pixel(9'd256, 9'd1); send_pixel(9'd0, 9'd511); send_pixel(9'd511, 9'd200);
    drain();

    // random phases, with a long receiver stall in one of them
    for (int ph = 0; ph < 12; ph++) begin
      camera_setup(ph % 3);
      if (ph == 10) calm = 1;
      if (ph == 3) hold_off = 60;
      for (int i = 0; i < 78; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(9'($urandom), 9'($urandom));
        else
          send_pixel(9'($urandom_range(150, 360)), 9'($urandom_range(0, 511)));
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
